@@ sv/sfdd_pkg.sv @@
package sfdd_pkg;

  localparam int unsigned MhzIntBits = 17;
  localparam int unsigned IdBits     = 16;
  localparam int unsigned CountBits  = 32;
  localparam int unsigned CfgIdxBits = 2;
  localparam int unsigned CfgBits    = 17;

  // Configuration register indexes
  localparam logic [CfgIdxBits-1:0] CfgNominal   = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgInitCount = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgThreshold = 2'd2;

  typedef struct packed {
    logic [15:0] station_id;
    logic        freq_format;
    logic [31:0] freq_raw;
  } in_t;

  typedef struct packed {
    logic        event_flag;
    logic        new_station;
    logic        table_full;
    logic [16:0] mean_mhz;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CHK, S_INS, S_PROD, S_CONV, S_DIFF, S_MUL, S_CMP, S_DIV, S_WB, S_FIN
  } state_e;

endpackage

@@ sv/sfdd_ram.sv @@
module sfdd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write one entry, register the read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/station_freq_deviation_detector.sv @@
// Channel | Direction | Handshake                  | Payload
// input   | in        | in_valid_i / in_stall_o    | in_data_i (in_t)
// output  | out       | out_valid_o / out_stall_i  | out_data_o (out_t)
// config  | in        | cfg_we_i                   | cfg_idx_i, cfg_wdata_i
//
// One transaction at a time. The station search reads the table memory one entry
// at a time, over up to MAX_STATIONS entries; a known station's reading is then
// converted and compared and, with no event, feeds the bit-serial mean divider.
// Reset clears the valid bits and sets the configuration to its defaults; no clearing pass is needed.
// A stalled output holds its result; the next transaction is taken once it is loaded.
module station_freq_deviation_detector
  import sfdd_pkg::*;
#(
  parameter int unsigned MAX_STATIONS   = 16,
  parameter int unsigned MEAN_FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CfgBits-1:0]    cfg_wdata_i
);

  localparam int unsigned IW  = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
  localparam int unsigned MW  = MhzIntBits + MEAN_FRAC_BITS;
  localparam int unsigned DW  = IdBits + MW + CountBits;
  localparam int unsigned PW  = MW + 14;
  localparam int unsigned CW  = $clog2(MW + 1);
  localparam logic [63:0] CurMax = (64'd1 << MW) - 64'd1;
  localparam logic [IW-1:0] LastIdx = IW'(MAX_STATIONS - 1);

  state_e state_q, state_d;

  logic [16:0] nominal_q;
  logic [15:0] init_cnt_q;
  logic [13:0] thr_q;

  logic [MAX_STATIONS-1:0] valid_q, valid_d;
  logic [IW-1:0] idx_q, idx_d, free_q, free_d;
  logic free_f_q, free_f_d;

  in_t in_q;
  out_t res_q, res_d, out_q;
  logic out_valid_q, out_valid_d;

  logic [MW-1:0] mean_q, mean_d, cur_q, cur_d, diff_q, diff_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic up_q, up_d;
  logic [33:0] prod_q, prod_d;
  logic signed [10:0] sh_q, sh_d;
  logic [PW-1:0] lhs_q, lhs_d, rhs_q, rhs_d;

  logic [MW-1:0] num_q, num_d, quo_q, quo_d;
  logic [33:0] rem_q, rem_d;
  logic [CW-1:0] dcnt_q, dcnt_d;

  logic ram_we;
  logic [IW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic [IdBits-1:0] rd_id;
  logic [MW-1:0] rd_mean;
  logic [CountBits-1:0] rd_cnt;

  sfdd_ram #(.Width(DW), .Depth(MAX_STATIONS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign {rd_id, rd_mean, rd_cnt} = ram_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nominal_q  <= 17'd50000;
      init_cnt_q <= 16'd500;
      thr_q      <= 14'd90;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgNominal:   nominal_q  <= cfg_wdata_i;
        CfgInitCount: init_cnt_q <= cfg_wdata_i[15:0];
        CfgThreshold: thr_q      <= cfg_wdata_i[13:0];
        default: ;
      endcase
    end
  end

  // Reading conversion helpers
  logic [23:0] ieee_m;
  logic [7:0]  ieee_ex;
  logic signed [18:0] fix_sum;
  logic [16:0] fix_val;
  logic [79:0] wide_up;
  logic [34:0] rnd_sum, rnd_val;
  logic [10:0] rsh;
  logic [63:0] ieee_cur;

  always_comb begin
    ieee_ex = (in_q.freq_raw[30:23] == 8'd0) ? 8'd1 : in_q.freq_raw[30:23];
    ieee_m  = (in_q.freq_raw[30:23] == 8'd0) ? {1'b0, in_q.freq_raw[22:0]}
                                             : {1'b1, in_q.freq_raw[22:0]};
    fix_sum = $signed({2'b00, nominal_q}) + 19'($signed(in_q.freq_raw[15:0]));
    if (fix_sum < 0) begin
      fix_val = 17'd0;
    end else if (fix_sum > 19'sd131071) begin
      fix_val = 17'h1FFFF;
    end else begin
      fix_val = fix_sum[16:0];
    end
    rsh     = 11'(-sh_q);
    wide_up = {46'd0, prod_q} << sh_q[6:0];
    rnd_sum = {1'b0, prod_q} + (35'd1 << (rsh[5:0] - 6'd1));
    rnd_val = rnd_sum >> rsh[5:0];
    ieee_cur = 64'd0;
    if (in_q.freq_raw[31]) begin
      ieee_cur = 64'd0;
    end else if (in_q.freq_raw[30:23] == 8'hFF) begin
      ieee_cur = (in_q.freq_raw[22:0] != 23'd0) ? 64'd0 : CurMax;
    end else if (prod_q == 34'd0) begin
      ieee_cur = 64'd0;
    end else if (sh_q >= 0) begin
      if (sh_q >= 11'(MW) || wide_up > {16'd0, CurMax}) begin
        ieee_cur = CurMax;
      end else begin
        ieee_cur = wide_up[63:0];
      end
    end else if (rsh >= 11'd40) begin
      ieee_cur = 64'd0;
    end else begin
      ieee_cur = ({29'd0, rnd_val} > CurMax) ? CurMax : {29'd0, rnd_val};
    end
  end

  // Divider step
  logic [33:0] trial;
  logic        q_bit;
  logic [32:0] divisor;
  assign divisor = {1'b0, cnt_q} + 33'd1;
  assign trial   = {rem_q[32:0], num_q[MW-1]};
  assign q_bit   = trial >= {1'b0, divisor};

  logic hit_now, free_now;
  assign hit_now  = valid_q[idx_q] && (rd_id == in_q.station_id);
  assign free_now = !valid_q[idx_q];

  // Next state and datapath
  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    idx_d       = idx_q;
    free_d      = free_q;
    free_f_d    = free_f_q;
    res_d       = res_q;
    out_valid_d = out_valid_q & out_stall_i;
    mean_d      = mean_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    diff_d      = diff_q;
    up_d        = up_q;
    prod_d      = prod_q;
    sh_d        = sh_q;
    lhs_d       = lhs_q;
    rhs_d       = rhs_q;
    num_d       = num_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q;
    ram_wdata   = {in_q.station_id, mean_q, cnt_q};
    in_stall_o  = (state_q != S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          idx_d    = '0;
          free_f_d = 1'b0;
          state_d  = S_RD;
        end
      end
      S_RD: state_d = S_CHK;
      S_CHK: begin
        if (hit_now) begin
          mean_d  = rd_mean;
          cnt_d   = rd_cnt;
          state_d = S_PROD;
        end else begin
          if (free_now && !free_f_q) begin
            free_f_d = 1'b1;
            free_d   = idx_q;
          end
          if (idx_q == LastIdx) begin
            if (free_now || free_f_q) begin
              state_d = S_INS;
            end else begin
              res_d   = '{event_flag: 1'b0, new_station: 1'b0, table_full: 1'b1,
                          mean_mhz: 17'd0};
              state_d = S_FIN;
            end
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = S_RD;
          end
        end
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = free_q;
        ram_wdata = {in_q.station_id, MW'({nominal_q, {MEAN_FRAC_BITS{1'b0}}}),
                     CountBits'(init_cnt_q)};
        valid_d[free_q] = 1'b1;
        res_d   = '{event_flag: 1'b0, new_station: 1'b1, table_full: 1'b0,
                    mean_mhz: nominal_q};
        state_d = S_FIN;
      end
      S_PROD: begin
        prod_d  = 34'(ieee_m) * 34'd1000;
        sh_d    = $signed({3'b000, ieee_ex}) - 11'sd150 + 11'(MEAN_FRAC_BITS);
        state_d = S_CONV;
      end
      S_CONV: begin
        cur_d   = in_q.freq_format ? ieee_cur[MW-1:0]
                                   : MW'({fix_val, {MEAN_FRAC_BITS{1'b0}}});
        state_d = S_DIFF;
      end
      S_DIFF: begin
        up_d    = cur_q >= mean_q;
        diff_d  = (cur_q >= mean_q) ? cur_q - mean_q : mean_q - cur_q;
        state_d = S_MUL;
      end
      S_MUL: begin
        lhs_d   = PW'(diff_q) * PW'(14'd10000);
        rhs_d   = PW'(thr_q) * PW'(mean_q);
        state_d = S_CMP;
      end
      S_CMP: begin
        if (lhs_q > rhs_q) begin
          res_d   = '{event_flag: 1'b1, new_station: 1'b0, table_full: 1'b0,
                      mean_mhz: mean_q[MW-1 -: MhzIntBits]};
          state_d = S_FIN;
        end else begin
          num_d   = diff_q;
          quo_d   = '0;
          rem_d   = '0;
          dcnt_d  = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d  = q_bit ? trial - {1'b0, divisor} : trial;
        quo_d  = {quo_q[MW-2:0], q_bit};
        num_d  = {num_q[MW-2:0], 1'b0};
        dcnt_d = dcnt_q + CW'(1);
        if (dcnt_q == CW'(MW - 1)) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        if (up_q) begin
          mean_d = mean_q + quo_q;
        end else begin
          mean_d = mean_q - quo_q - MW'(rem_q != 34'd0);
        end
        if (cnt_q != {CountBits{1'b1}}) begin
          cnt_d = cnt_q + CountBits'(1);
        end
        ram_we    = 1'b1;
        ram_wdata = {in_q.station_id, mean_d, cnt_d};
        res_d     = '{event_flag: 1'b0, new_station: 1'b0, table_full: 1'b0,
                      mean_mhz: mean_d[MW-1 -: MhzIntBits]};
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      free_f_q    <= 1'b0;
      dcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      free_f_q    <= free_f_d;
      dcnt_q      <= dcnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (state_q == S_FIN && (!out_valid_q || !out_stall_i)) begin
      out_q <= res_q;
    end
    free_q <= free_d;
    res_q  <= res_d;
    mean_q <= mean_d;
    cnt_q  <= cnt_d;
    cur_q  <= cur_d;
    diff_q <= diff_d;
    up_q   <= up_d;
    prod_q <= prod_d;
    sh_q   <= sh_d;
    lhs_q  <= lhs_d;
    rhs_q  <= rhs_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // At most one status flag per result
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({out_data_o.event_flag, out_data_o.new_station,
                                out_data_o.table_full}) <= 1)
    else $error("conflicting result flags");

  // Table writes only on insertion or mean write-back
  a_ram_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_INS || state_q == S_WB))
    else $error("table write outside insert or write-back");

  // An insertion sets exactly one new valid bit
  a_ins_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INS |=> $countones(valid_q) == $countones($past(valid_q)) + 1)
    else $error("insertion did not add one entry");

  // Divider never runs past its width
  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> dcnt_q < CW'(MW))
    else $error("divider count overrun");

endmodule

@@ verif/testbench.sv @@
module testbench;
  import sfdd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumEntries = 16;
  localparam int unsigned FracBits   = 16;
  localparam logic [63:0] ReadingMax = (64'd1 << (MhzIntBits + FracBits)) - 1;
  localparam int unsigned IdleLimit  = 4000;
  localparam logic [CfgIdxBits-1:0] CfgUnused = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx = '0;
  logic [CfgBits-1:0]    cfg_wdata = '0;

  station_freq_deviation_detector #(
    .MAX_STATIONS  (NumEntries),
    .MEAN_FRAC_BITS(FracBits)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor state: configuration and station table
  logic [16:0] nominal_mhz;
  logic [15:0] start_count;
  logic [13:0] thresh_bp;
  logic        stn_valid [NumEntries];
  logic [15:0] stn_id    [NumEntries];
  logic [63:0] stn_mean  [NumEntries];
  logic [31:0] stn_count [NumEntries];

  out_t        expected_results[$];
  int          error_count = 0;
  bit          calm = 1'b0;
  logic [15:0] station_pool[NumEntries];

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(13, 0);
  endfunction

  function automatic logic [63:0] fixed_to_mhz(logic [31:0] raw);
    int dev;
    int v;
    dev = int'(signed'(raw[15:0]));
    v = int'(nominal_mhz) + dev;
    if (v < 0) v = 0;
    if (v > 131071) v = 131071;
    return 64'(v) << FracBits;
  endfunction

  function automatic logic [63:0] float_to_mhz(logic [31:0] w);
    logic [7:0]  ex;
    logic [63:0] mant;
    logic [63:0] prod;
    logic [63:0] v;
    int          sh;
    int          r;
    ex = w[30:23];
    if (w[31]) return 64'd0;
    if (ex == 8'hFF) return (w[22:0] != 0) ? 64'd0 : ReadingMax;
    if (ex == 8'd0) begin
      mant = 64'(w[22:0]);
      ex = 8'd1;
    end else begin
      mant = 64'({1'b1, w[22:0]});
    end
    prod = mant * 64'd1000;
    if (prod == 0) return 64'd0;
    sh = int'(ex) - 150 + int'(FracBits);
    if (sh >= 0) begin
      if (sh >= 48 || prod > (ReadingMax >> sh)) return ReadingMax;
      return prod << sh;
    end
    r = -sh;
    if (r >= 40) return 64'd0;
    v = (prod + (64'd1 << (r - 1))) >> r;
    return (v > ReadingMax) ? ReadingMax : v;
  endfunction

  // Apply one reading to the station table and return the expected result
  function automatic out_t track_station(in_t item);
    out_t        res;
    int          hit;
    int          free_slot;
    logic [63:0] cur;
    logic [63:0] mean;
    logic [63:0] diff;
    logic [63:0] div;
    res = '0;
    hit = -1;
    free_slot = -1;
    for (int i = 0; i < NumEntries; i++) begin
      if (stn_valid[i]) begin
        if (hit < 0 && stn_id[i] == item.station_id) hit = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit < 0) begin
      if (free_slot < 0) begin
        res.table_full = 1'b1;
        return res;
      end
      stn_valid[free_slot] = 1'b1;
      stn_id[free_slot] = item.station_id;
      stn_mean[free_slot] = 64'(nominal_mhz) << FracBits;
      stn_count[free_slot] = 32'(start_count);
      res.new_station = 1'b1;
      res.mean_mhz = nominal_mhz;
      return res;
    end
    cur = item.freq_format ? float_to_mhz(item.freq_raw) : fixed_to_mhz(item.freq_raw);
    mean = stn_mean[hit];
    diff = (cur >= mean) ? cur - mean : mean - cur;
    div = 64'(stn_count[hit]) + 64'd1;
    if (diff * 64'd10000 > 64'(thresh_bp) * mean) begin
      res.event_flag = 1'b1;
    end else begin
      if (cur >= mean) mean = mean + diff / div;
      else mean = mean - (diff + div - 64'd1) / div;
      stn_mean[hit] = mean;
      if (stn_count[hit] != 32'hFFFF_FFFF) stn_count[hit] = stn_count[hit] + 32'd1;
    end
    res.mean_mhz = stn_mean[hit][FracBits +: 17];
    return res;
  endfunction

  // Send one reading; keep valid high when no gap follows the last transaction
  task automatic send_reading(logic [15:0] id, logic fmt, logic [31:0] raw);
    int unsigned gap;
    in_t         item;
    gap = draw_wait();
    item.station_id = id;
    item.freq_format = fmt;
    item.freq_raw = raw;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(track_station(item));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgBits-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgNominal:   nominal_mhz = value[16:0];
      CfgInitCount: start_count = value[15:0];
      CfgThreshold: thresh_bp = value[13:0];
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch %s: got %0d, expected %0d", field, got, want);
    error_count++;
  endtask

  // Draw output stalls per result
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      stall_left = draw_wait();
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left > 0);
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result transaction", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.event_flag !== want.event_flag)
          report_mismatch("event_flag", out_data.event_flag, want.event_flag);
        if (out_data.new_station !== want.new_station)
          report_mismatch("new_station", out_data.new_station, want.new_station);
        if (out_data.table_full !== want.table_full)
          report_mismatch("table_full", out_data.table_full, want.table_full);
        if (out_data.mean_mhz !== want.mean_mhz)
          report_mismatch("mean_mhz", out_data.mean_mhz, want.mean_mhz);
      end
    end
  end

  // End the run when no transaction moves for too long
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("testbench failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Fill most of the table, touching every id bit both ways
  task automatic test_new_stations();
    station_pool[0] = 16'h0000;
    station_pool[1] = 16'hFFFF;
    for (int i = 2; i < NumEntries; i++) station_pool[i] = 16'(i * 16'h0F0F + 16'h1234);
    for (int i = 0; i < NumEntries - 2; i++) send_reading(station_pool[i], 1'b0, 32'd0);
  endtask

  // Fixed and float corner readings against known stations
  task automatic test_reading_corners();
    write_reg(CfgThreshold, 17'd10000);
    send_reading(station_pool[0], 1'b0, 32'h0000_7FFF);
    send_reading(station_pool[1], 1'b0, 32'hFFFF_8000);
    send_reading(station_pool[2], 1'b0, 32'hABCD_0000);
    send_reading(station_pool[3], 1'b1, 32'h0000_0000);
    send_reading(station_pool[3], 1'b1, 32'h8000_0000);
    send_reading(station_pool[4], 1'b1, 32'hC248_0000);
    send_reading(station_pool[4], 1'b1, 32'h7FC0_0001);
    send_reading(station_pool[5], 1'b1, 32'h7F80_0000);
    send_reading(station_pool[6], 1'b1, 32'h7F7F_FFFF);
    send_reading(station_pool[7], 1'b1, 32'h0000_0001);
    send_reading(station_pool[7], 1'b1, 32'h007F_FFFF);
    send_reading(station_pool[8], 1'b1, 32'h4248_0000);
    send_reading(station_pool[8], 1'b1, 32'h3A83_126F);
    send_reading(station_pool[9], 1'b1, 32'h4248_0001);
    write_reg(CfgThreshold, 17'd90);
  endtask

  // A zero mean flags any nonzero difference; a zero threshold flags any change
  task automatic test_zero_mean();
    write_reg(CfgNominal, 17'd0);
    write_reg(CfgInitCount, 17'd1);
    send_reading(station_pool[14], 1'b0, 32'd0);
    send_reading(station_pool[14], 1'b0, 32'd0);
    send_reading(station_pool[14], 1'b0, 32'd1);
    write_reg(CfgThreshold, 17'd0);
    send_reading(station_pool[14], 1'b1, 32'h0000_0000);
    send_reading(station_pool[14], 1'b1, 32'h3F80_0000);
    write_reg(CfgNominal, 17'd131071);
    write_reg(CfgInitCount, 17'd65535);
    write_reg(CfgUnused, 17'h1FFFF);
    send_reading(station_pool[15], 1'b0, 32'd0);
    send_reading(station_pool[15], 1'b0, 32'd0);
  endtask

  // Unknown ids once the table is full
  task automatic test_table_full();
    send_reading(16'h5A5A, 1'b0, 32'd0);
    send_reading(16'hA5A4, 1'b1, 32'h4248_0000);
  endtask

  function automatic logic [31:0] draw_raw(logic fmt);
    case ($urandom_range(3, 0))
      0: return $urandom();
      1: return fmt ? {9'b0_1000_0100, 23'($urandom())} : {16'($urandom()), 16'($urandom())};
      default: return fmt ? {9'b0_1000_0100, 5'b10010, 18'($urandom())}
                          : {16'($urandom()), 16'($signed($urandom_range(400, 0)) - 16'sd200)};
    endcase
  endfunction

  // Random readings, mostly from known stations, under several settings
  task automatic test_random_traffic();
    logic fmt;
    logic [15:0] id;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(CfgNominal, 17'd50000);
          write_reg(CfgThreshold, 17'd10000);
        end
        1: write_reg(CfgThreshold, 17'd90);
        2: begin
          write_reg(CfgNominal, 17'($urandom_range(131071, 0)));
          write_reg(CfgThreshold, 17'($urandom_range(10000, 0)));
        end
        default: begin
          write_reg(CfgNominal, 17'($urandom_range(60000, 40000)));
          write_reg(CfgThreshold, 17'($urandom_range(2000, 0)));
        end
      endcase
      for (int n = 0; n < 300; n++) begin
        calm = ((n / 60) % 3 == 2);
        fmt = $urandom_range(1, 0);
        id = ($urandom_range(9, 0) == 0) ? 16'($urandom())
                                         : station_pool[$urandom_range(NumEntries - 1, 0)];
        send_reading(id, fmt, draw_raw(fmt));
        if (n == 150) drain();
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    nominal_mhz = 17'd50000;
    start_count = 16'd500;
    thresh_bp = 14'd90;
    for (int i = 0; i < NumEntries; i++) begin
      stn_valid[i] = 1'b0;
      stn_id[i] = '0;
      stn_mean[i] = '0;
      stn_count[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_new_stations();
    test_reading_corners();
    test_zero_mean();
    test_table_full();
    test_random_traffic();
    drain();
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/sfdd_pkg.sv
sv/sfdd_ram.sv
sv/station_freq_deviation_detector.sv
verif/testbench.sv
